### rtl/core/hba_pkg.sv
// Shared types and constants for the headset button classifier with
// self-learning forward/back split. No dependencies.
package hba_pkg;

    // Learning phase: first record expected, second expected, both known.
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Entry stage codes carried with each input beat.
    localparam logic [2:0] STG_CHECK  = 3'd0;
    localparam logic [2:0] STG_MARGIN = 3'd1;
    localparam logic [2:0] STG_RECORD = 3'd2;
    localparam logic [2:0] STG_READJ  = 3'd3;
    localparam logic [2:0] STG_REPORT = 3'd4;

    // Button codes of a result.
    localparam logic [1:0] BTN_HOOK    = 2'd0;
    localparam logic [1:0] BTN_FORWARD = 2'd1;
    localparam logic [1:0] BTN_BACK    = 2'd2;
    localparam logic [1:0] BTN_NONE    = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_ADDR_W      = 3;
    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_HOOK_MIN    = 3'd1;
    localparam logic [2:0] REG_HOOK_MAX    = 3'd2;
    localparam logic [2:0] REG_FORWARD_MIN = 3'd3;
    localparam logic [2:0] REG_FWD_MAX_INI = 3'd4;
    localparam logic [2:0] REG_BACK_MIN_INI = 3'd5;
    localparam logic [2:0] REG_BACK_MAX    = 3'd6;

    // Reset values of the registers.
    localparam int RST_HOOK_MIN     = 0;
    localparam int RST_HOOK_MAX     = 135;
    localparam int RST_FORWARD_MIN  = 136;
    localparam int RST_FWD_MAX_INI  = 350;
    localparam int RST_BACK_MIN_INI = 351;
    localparam int RST_BACK_MAX     = 700;

    // Stream side widths that do not follow the sample width.
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 8;

endpackage

### rtl/core/headset_button_autocalib.sv
// Headset button classifier that learns its forward/back split from the samples.
// Depends on hba_pkg for the phase type, stage, button and register codes.
//
// Channel   | Direction | Beat contents (lowest bit first)
// s_axis    | in        | tuser: command, start_stage; tdata: sample
// m_axis    | out       | tuser: reported; tdata: button
// cfg       | in        | i_cfg_we, i_cfg_addr (register index), i_cfg_data
//
// An accepted beat sits in the input register and is classified, once the result
// register is free or being taken, by one pass of logic that also updates the
// learned state and loads the result register, so one beat is taken per cycle
// while the output is not stalled. A stalled result holds the input register; the
// input side stalls only when both registers are full. Reset is synchronous and active low.
module headset_button_autocalib #(
    parameter int SAMPLE_BITS    = 12,
    parameter int DEFAULT_MARGIN = 35,
    localparam int IN_DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_DATA_W-1:0]          s_axis_tdata,   // sample
    input  logic [hba_pkg::IN_USER_W-1:0] s_axis_tuser,   // command, start_stage
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hba_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // button
    output logic [0:0]                    m_axis_tuser,   // reported
    input  logic                          i_cfg_we,
    input  logic [hba_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [SAMPLE_BITS:0]          i_cfg_data
);
    import hba_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic          r_in_valid;
    logic          r_in_cmd;
    logic [2:0]    r_in_stage;
    logic [SB-1:0] r_in_sample;
    logic          r_out_valid;
    logic          r_out_reported;
    logic [1:0]    r_out_button;

    logic          r_enable;
    logic [SB-1:0] r_hook_min;
    logic [SB-1:0] r_hook_max;
    logic [SB-1:0] r_forward_min;
    logic [SB-1:0] r_back_max;

    t_phase        r_phase;
    logic [SB:0]   r_low_rec;
    logic [SB:0]   r_high_rec;
    logic [SB-1:0] r_low_margin;
    logic [SB-1:0] r_high_margin;
    logic [SB-1:0] r_widest_gap;
    logic [SB:0]   r_fwd_max;
    logic [SB:0]   r_back_min;

    t_phase        n_phase;
    logic [SB:0]   n_low_rec;
    logic [SB:0]   n_high_rec;
    logic [SB-1:0] n_low_margin;
    logic [SB-1:0] n_high_margin;
    logic [SB-1:0] n_widest_gap;
    logic [SB:0]   n_fwd_max;
    logic [SB:0]   n_back_min;
    logic          n_reported;
    logic [1:0]    n_button;

    logic          advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, r_out_button};
    assign m_axis_tuser  = r_out_reported;

    always_comb begin
        logic [SB-1:0] low_u;
        logic [SB-1:0] high_u;
        logic [SB-1:0] diff_low;
        logic [SB-1:0] diff_high;
        logic [SB-1:0] span;
        logic [SB-1:0] gap;
        logic [SB-1:0] lim;
        logic [SB-1:0] lm;
        logic [SB+1:0] sum;
        logic [SB+1:0] sum_rnd;
        logic          is_valid;
        logic          margin_chk;
        logic          in_margin;
        logic          rec_stage;
        logic          take;
        logic          readj;

        n_phase       = r_phase;
        n_low_rec     = r_low_rec;
        n_high_rec    = r_high_rec;
        n_low_margin  = r_low_margin;
        n_high_margin = r_high_margin;
        n_widest_gap  = r_widest_gap;
        n_fwd_max     = r_fwd_max;
        n_back_min    = r_back_min;
        n_reported    = 1'b0;
        n_button      = BTN_NONE;

        low_u     = r_low_rec[SB-1:0];
        high_u    = r_high_rec[SB-1:0];
        diff_low  = (r_in_sample > low_u) ? r_in_sample - low_u : low_u - r_in_sample;
        diff_high = (r_in_sample > high_u) ? r_in_sample - high_u : high_u - r_in_sample;
        is_valid  = r_enable && (r_in_sample <= r_back_max) && (r_in_stage <= STG_REPORT);

        // A record check with no record known goes straight to recording.
        margin_chk = (r_in_stage == STG_MARGIN)
                  || (r_in_stage == STG_CHECK && r_phase != PH_FIRST);
        in_margin  = (r_phase != PH_FIRST && diff_low < r_low_margin)
                  || (r_phase == PH_DONE && diff_high < r_high_margin);
        rec_stage  = (r_in_stage == STG_RECORD)
                  || (r_in_stage == STG_CHECK && r_phase == PH_FIRST)
                  || (margin_chk && !in_margin);
        take       = rec_stage && (r_in_sample >= r_hook_max);
        readj      = 1'b0;
        span       = '0;
        gap        = '0;
        lim        = '0;
        lm         = '0;
        sum        = '0;
        sum_rnd    = '0;

        if (r_in_cmd) begin
            n_low_rec     = '1;
            n_high_rec    = '1;
            n_low_margin  = SB'(DEFAULT_MARGIN);
            n_high_margin = SB'(DEFAULT_MARGIN);
            n_phase       = PH_FIRST;
        end else if (is_valid) begin
            if (take) begin
                case (r_phase)
                    PH_FIRST: begin
                        n_low_rec = {1'b0, r_in_sample};
                        n_phase   = PH_SECOND;
                    end
                    PH_SECOND: begin
                        if (r_in_sample > low_u) begin
                            n_high_rec = {1'b0, r_in_sample};
                        end else begin
                            n_high_rec = r_low_rec;
                            n_low_rec  = {1'b0, r_in_sample};
                        end
                        n_phase = PH_DONE;
                    end
                    PH_DONE: begin
                        if (r_in_sample < low_u) begin
                            n_low_rec = {1'b0, r_in_sample};
                        end else if (r_in_sample > high_u) begin
                            n_high_rec = {1'b0, r_in_sample};
                        end
                    end
                    default: begin
                    end
                endcase
                if (r_phase == PH_SECOND || r_phase == PH_DONE) begin
                    span = n_high_rec[SB-1:0] - n_low_rec[SB-1:0];
                    gap  = (span > r_widest_gap) ? span : r_widest_gap;
                    lm   = gap >> 1;
                    if (n_low_rec[SB-1:0] >= r_hook_max) begin
                        lim = (n_low_rec[SB-1:0] - r_hook_max) >> 1;
                        if (lim < lm) begin
                            lm = lim;
                        end
                    end
                    n_widest_gap  = gap;
                    n_low_margin  = lm;
                    n_high_margin = gap - lm;
                end
            end

            // The midpoint of the records rounds toward zero; an empty record is -1.
            readj = (r_in_stage == STG_READJ) || (rec_stage && n_phase == PH_DONE);
            if (readj) begin
                sum        = {n_low_rec[SB], n_low_rec} + {n_high_rec[SB], n_high_rec};
                sum_rnd    = sum + {{(SB + 1){1'b0}}, sum[SB+1]};
                n_fwd_max  = sum_rnd[SB+1:1];
                n_back_min = sum_rnd[SB+1:1] + {{SB{1'b0}}, 1'b1};
            end

            n_reported = 1'b1;
            if (r_in_sample >= r_hook_min && r_in_sample <= r_hook_max) begin
                n_button = BTN_HOOK;
            end else if (r_in_sample >= r_forward_min && {1'b0, r_in_sample} <= n_fwd_max) begin
                n_button = BTN_FORWARD;
            end else if ({1'b0, r_in_sample} >= n_back_min && r_in_sample <= r_back_max) begin
                n_button = BTN_BACK;
            end else begin
                n_button = BTN_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_enable      <= 1'b0;
            r_hook_min    <= SB'(RST_HOOK_MIN);
            r_hook_max    <= SB'(RST_HOOK_MAX);
            r_forward_min <= SB'(RST_FORWARD_MIN);
            r_back_max    <= SB'(RST_BACK_MAX);
            r_phase       <= PH_FIRST;
            r_low_rec     <= '1;
            r_high_rec    <= '1;
            r_low_margin  <= SB'(DEFAULT_MARGIN);
            r_high_margin <= SB'(DEFAULT_MARGIN);
            r_widest_gap  <= SB'(DEFAULT_MARGIN);
            r_fwd_max     <= (SB + 1)'(RST_FWD_MAX_INI);
            r_back_min    <= (SB + 1)'(RST_BACK_MIN_INI);
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_phase       <= n_phase;
                r_low_rec     <= n_low_rec;
                r_high_rec    <= n_high_rec;
                r_low_margin  <= n_low_margin;
                r_high_margin <= n_high_margin;
                r_widest_gap  <= n_widest_gap;
                r_fwd_max     <= n_fwd_max;
                r_back_min    <= n_back_min;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ENABLE:       r_enable      <= i_cfg_data[0];
                    REG_HOOK_MIN:     r_hook_min    <= i_cfg_data[SB-1:0];
                    REG_HOOK_MAX:     r_hook_max    <= i_cfg_data[SB-1:0];
                    REG_FORWARD_MIN:  r_forward_min <= i_cfg_data[SB-1:0];
                    REG_FWD_MAX_INI:  r_fwd_max     <= {1'b0, i_cfg_data[SB-1:0]};
                    REG_BACK_MIN_INI: r_back_min    <= i_cfg_data;
                    REG_BACK_MAX:     r_back_max    <= i_cfg_data[SB-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd    <= s_axis_tuser[0];
            r_in_stage  <= s_axis_tuser[3:1];
            r_in_sample <= s_axis_tdata[SB-1:0];
        end
        if (advance) begin
            r_out_reported <= n_reported;
            r_out_button   <= n_button;
        end
    end

endmodule
